// ----- design/vat_pkg.sv -----
// ----------------------------------------------------------------------------
// vat_pkg: shared types and constants of the vertex affine transform
// Request structs of both channels, the coefficient bundle handed to the
// datapath, mode codes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package vat_pkg;

    localparam int CoordW   = 32;
    localparam int AngleW   = 17;
    localparam int ModeW    = 3;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 32;
    // Widest series divisor is 48 * 49 = 2352.
    localparam int DivW     = 12;

    // Operation codes held in the mode register.
    localparam logic [ModeW-1:0] MODE_MOVE_X = 3'd0;
    localparam logic [ModeW-1:0] MODE_MOVE_Y = 3'd1;
    localparam logic [ModeW-1:0] MODE_MOVE_Z = 3'd2;
    localparam logic [ModeW-1:0] MODE_ROT_X  = 3'd3;
    localparam logic [ModeW-1:0] MODE_ROT_Y  = 3'd4;
    localparam logic [ModeW-1:0] MODE_ROT_Z  = 3'd5;
    localparam logic [ModeW-1:0] MODE_SCALE  = 3'd6;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_MODE   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_OFFSET = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_ANGLE  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_SCALE  = 2'd3;

    localparam logic signed [CoordW-1:0] SCALE_RESET = 32'sd65536;
    localparam logic signed [CoordW-1:0] Q30_ONE     = 32'sd1073741824;
    localparam logic signed [CoordW-1:0] SAT_MAX     = 32'sh7FFFFFFF;
    localparam logic signed [CoordW-1:0] SAT_MIN     = 32'sh80000000;

    typedef struct packed {
        logic signed [CoordW-1:0] vertex_x;
        logic signed [CoordW-1:0] vertex_y;
        logic signed [CoordW-1:0] vertex_z;
        logic                     last_in;
    } vtx_t;

    typedef struct packed {
        logic signed [CoordW-1:0] out_x;
        logic signed [CoordW-1:0] out_y;
        logic signed [CoordW-1:0] out_z;
        logic                     overflow;
        logic                     last_out;
    } res_t;

    typedef struct packed {
        logic [ModeW-1:0]         mode;
        logic signed [CoordW-1:0] offset;
        logic signed [CoordW-1:0] scale;
        logic signed [CoordW-1:0] cos_q30;
        logic signed [CoordW-1:0] sin_q30;
    } coef_t;

endpackage

// ----- design/vat_mul64.sv -----
// ----------------------------------------------------------------------------
// vat_mul64: iterative 64 x 64 unsigned multiplier
// Forms the full 128-bit product from four 32 x 32 partial products, one per
// cycle, each registered before it is added into the accumulator.
// ----------------------------------------------------------------------------
module vat_mul64 (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);

    localparam logic [2:0] LastStep = 3'd4;

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic         pp_live_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] pp_ext;

    // Pick the operand halves for this step and align the last partial product.
    always_comb
    begin
        a_half = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
        b_half = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
        case (pp_sh_reg)
            2'd1:    pp_ext = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_ext = {pp_reg, 64'd0};
            default: pp_ext = {64'd0, pp_reg};
        endcase
    end

    // Step control; a new start always takes over.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= 3'd0;
            pp_live_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
            cnt_reg     <= 3'd0;
            pp_live_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != LastStep)
            begin
                cnt_reg     <= cnt_reg + 3'd1;
                pp_live_reg <= 1'b1;
            end
            else
            begin
                busy_reg    <= 1'b0;
                pp_live_reg <= 1'b0;
                done_reg    <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Operands, partial products and accumulator.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (pp_live_reg)
            begin
                acc_reg <= acc_reg + pp_ext;
            end
            if (cnt_reg != LastStep)
            begin
                pp_reg    <= a_half * b_half;
                pp_sh_reg <= {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- design/vat_div64.sv -----
// ----------------------------------------------------------------------------
// vat_div64: radix-2 restoring divider
// Divides a 64-bit unsigned value by a narrow divisor, one quotient bit per
// cycle, and truncates.
// ----------------------------------------------------------------------------
module vat_div64 (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [63:0]              dividend,
    input  logic [vat_pkg::DivW-1:0] divisor,
    output logic                     done,
    output logic [63:0]              quotient
);

    localparam int DW   = vat_pkg::DivW;
    localparam int DvdW = 64;
    localparam int CntW = $clog2(DvdW);

    logic            busy_reg;
    logic            done_reg;
    logic [CntW-1:0] cnt_reg;
    logic [DvdW-1:0] quo_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   dsr_reg;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            fits;
    logic [DW-1:0]   rem_next;
    logic [DvdW-1:0] quo_next;

    // One restoring step: bring in the next dividend bit and try a subtract.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DvdW-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
        quo_next = {quo_reg[DvdW-2:0], fits};
    end

    // Bit counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CntW'(1);
            if (cnt_reg == CntW'(DvdW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Shifting dividend / quotient word and partial remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/vat_trig.sv -----
// ----------------------------------------------------------------------------
// vat_trig: cosine and sine sequencer
// Reduces the angle to an octant, evaluates the sine and cosine Taylor series
// in Q2.62 on a shared multiplier and divider, and rounds both to Q2.30.
// ----------------------------------------------------------------------------
module vat_trig (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [vat_pkg::AngleW-1:0] angle,
    output logic                              busy,
    output logic signed [vat_pkg::CoordW-1:0] cos_q30,
    output logic signed [vat_pkg::CoordW-1:0] sin_q30
);

    localparam int AW = vat_pkg::AngleW;
    localparam int CW = vat_pkg::CoordW;
    localparam int DivW = vat_pkg::DivW;

    localparam logic [63:0] PiQ62     = 64'hC90FDAA22168C235;
    // One angle step (1/128 degree) in radians, Q2.62.
    localparam logic [63:0] AngleUnit = PiQ62 / 64'd23040;
    localparam logic [63:0] OneQ62    = 64'h4000000000000000;
    localparam logic [63:0] RoundHalf = 64'h0000000080000000;

    localparam logic signed [AW:0] FullTurn = 18'sd46080;
    localparam logic [15:0] Turn1Q = 16'd11520;
    localparam logic [15:0] Turn2Q = 16'd23040;
    localparam logic [15:0] Turn3Q = 16'd34560;
    localparam logic [13:0] QuarterR = 14'd11520;
    localparam logic [13:0] EighthR  = 14'd5760;
    localparam logic [4:0]  MaxTerm  = 5'd24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_TMUL,
        ST_TWAIT,
        ST_T2MUL,
        ST_T2WAIT,
        ST_INIT,
        ST_TERM_MUL,
        ST_TERM_WAIT,
        ST_DIV_WAIT,
        ST_ROUND,
        ST_FINISH
    } state_t;

    state_t                state_reg;
    logic                  busy_reg;
    logic signed [AW-1:0]  ang_reg;
    logic [1:0]            quad_reg;
    logic                  swap_reg;
    logic [12:0]           red_reg;
    logic [63:0]           t_reg;
    logic [63:0]           t2_reg;
    logic [63:0]           term_reg;
    logic [63:0]           sum_reg;
    logic [4:0]            k_reg;
    logic                  odd_reg;
    logic signed [CW-1:0]  sin_ser_reg;
    logic signed [CW-1:0]  cos_ser_reg;
    logic signed [CW-1:0]  cos_reg;
    logic signed [CW-1:0]  sin_reg;
    logic                  mul_start_reg;
    logic [63:0]           mul_a_reg;
    logic [63:0]           mul_b_reg;
    logic                  div_start_reg;
    logic [63:0]           div_dvd_reg;

    logic                  mul_done;
    logic [127:0]          mul_prod;
    logic                  div_done;
    logic [63:0]           div_quo;

    logic signed [AW:0]    a_ext;
    logic signed [AW:0]    m_a;
    logic signed [AW:0]    m_b;
    logic [15:0]           mod_u;
    logic [15:0]           base;
    logic [1:0]            quad;
    logic [13:0]           rem_q;
    logic                  swap;
    logic [12:0]           red;
    logic [5:0]            k2;
    logic [5:0]            kother;
    logic [DivW-1:0]       dvs;
    logic [63:0]           rnd_sum;
    logic signed [CW-1:0]  c0;
    logic signed [CW-1:0]  s0;
    logic signed [CW-1:0]  c_fin;
    logic signed [CW-1:0]  s_fin;

    vat_mul64 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    vat_div64 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Angle reduction to a full turn, then to quadrant and octant.
    always_comb
    begin
        a_ext = $signed({ang_reg[AW-1], ang_reg});
        if (a_ext < 18'sd0)
        begin
            m_a = a_ext + FullTurn;
        end
        else if (a_ext >= FullTurn)
        begin
            m_a = a_ext - FullTurn;
        end
        else
        begin
            m_a = a_ext;
        end
        m_b   = (m_a < 18'sd0) ? m_a + FullTurn : m_a;
        mod_u = m_b[15:0];
        if (mod_u >= Turn3Q)
        begin
            quad = 2'd3;
            base = Turn3Q;
        end
        else if (mod_u >= Turn2Q)
        begin
            quad = 2'd2;
            base = Turn2Q;
        end
        else if (mod_u >= Turn1Q)
        begin
            quad = 2'd1;
            base = Turn1Q;
        end
        else
        begin
            quad = 2'd0;
            base = 16'd0;
        end
        rem_q = 14'(mod_u - base);
        swap  = rem_q > EighthR;
        red   = swap ? 13'(QuarterR - rem_q) : rem_q[12:0];
    end

    // Series divisor for term k: (2k)(2k+1) for sine, (2k-1)(2k) for cosine.
    always_comb
    begin
        k2     = {k_reg, 1'b0};
        kother = odd_reg ? k2 + 6'd1 : k2 - 6'd1;
        dvs    = DivW'(k2) * DivW'(kother);
    end

    // Rounding to Q30 and final sign placement from the quadrant.
    always_comb
    begin
        rnd_sum = sum_reg + RoundHalf;
        c0      = swap_reg ? sin_ser_reg : cos_ser_reg;
        s0      = swap_reg ? cos_ser_reg : sin_ser_reg;
        case (quad_reg)
            2'd0:
            begin
                c_fin = c0;
                s_fin = s0;
            end
            2'd1:
            begin
                c_fin = -s0;
                s_fin = c0;
            end
            2'd2:
            begin
                c_fin = -c0;
                s_fin = -s0;
            end
            default:
            begin
                c_fin = s0;
                s_fin = -c0;
            end
        endcase
    end

    // Sequencer. A done pulse is taken only once the matching start has gone.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            ang_reg       <= '0;
            quad_reg      <= 2'd0;
            swap_reg      <= 1'b0;
            red_reg       <= '0;
            t_reg         <= '0;
            t2_reg        <= '0;
            term_reg      <= '0;
            sum_reg       <= '0;
            k_reg         <= 5'd1;
            odd_reg       <= 1'b1;
            sin_ser_reg   <= '0;
            cos_ser_reg   <= '0;
            cos_reg       <= vat_pkg::Q30_ONE;
            sin_reg       <= '0;
            mul_start_reg <= 1'b0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            div_start_reg <= 1'b0;
            div_dvd_reg   <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (start)
            begin
                ang_reg   <= angle;
                busy_reg  <= 1'b1;
                state_reg <= ST_REDUCE;
            end
            else
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        busy_reg <= 1'b0;
                    end
                    ST_REDUCE:
                    begin
                        quad_reg  <= quad;
                        swap_reg  <= swap;
                        red_reg   <= red;
                        state_reg <= ST_TMUL;
                    end
                    ST_TMUL:
                    begin
                        mul_a_reg     <= 64'(red_reg);
                        mul_b_reg     <= AngleUnit;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_TWAIT;
                    end
                    ST_TWAIT:
                    begin
                        if (mul_done && !mul_start_reg)
                        begin
                            t_reg     <= mul_prod[63:0];
                            state_reg <= ST_T2MUL;
                        end
                    end
                    ST_T2MUL:
                    begin
                        mul_a_reg     <= t_reg;
                        mul_b_reg     <= t_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_T2WAIT;
                    end
                    ST_T2WAIT:
                    begin
                        if (mul_done && !mul_start_reg)
                        begin
                            t2_reg    <= mul_prod[125:62];
                            odd_reg   <= 1'b1;
                            state_reg <= ST_INIT;
                        end
                    end
                    ST_INIT:
                    begin
                        term_reg  <= odd_reg ? t_reg : OneQ62;
                        sum_reg   <= odd_reg ? t_reg : OneQ62;
                        k_reg     <= 5'd1;
                        state_reg <= ST_TERM_MUL;
                    end
                    ST_TERM_MUL:
                    begin
                        mul_a_reg     <= term_reg;
                        mul_b_reg     <= t2_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_TERM_WAIT;
                    end
                    ST_TERM_WAIT:
                    begin
                        if (mul_done && !mul_start_reg)
                        begin
                            div_dvd_reg   <= mul_prod[125:62];
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_DIV_WAIT;
                        end
                    end
                    ST_DIV_WAIT:
                    begin
                        if (div_done && !div_start_reg)
                        begin
                            if (div_quo == 64'd0)
                            begin
                                state_reg <= ST_ROUND;
                            end
                            else
                            begin
                                term_reg <= div_quo;
                                sum_reg  <= k_reg[0] ? sum_reg - div_quo : sum_reg + div_quo;
                                if (k_reg == MaxTerm)
                                begin
                                    state_reg <= ST_ROUND;
                                end
                                else
                                begin
                                    k_reg     <= k_reg + 5'd1;
                                    state_reg <= ST_TERM_MUL;
                                end
                            end
                        end
                    end
                    ST_ROUND:
                    begin
                        if (odd_reg)
                        begin
                            sin_ser_reg <= $signed(rnd_sum[63:32]);
                            odd_reg     <= 1'b0;
                            state_reg   <= ST_INIT;
                        end
                        else
                        begin
                            cos_ser_reg <= $signed(rnd_sum[63:32]);
                            state_reg   <= ST_FINISH;
                        end
                    end
                    ST_FINISH:
                    begin
                        cos_reg   <= c_fin;
                        sin_reg   <= s_fin;
                        busy_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign busy    = busy_reg;
    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule

// ----- design/vat_datapath.sv -----
// ----------------------------------------------------------------------------
// vat_datapath: four-stage vertex pipeline
// Each coordinate lane forms m0*v0 + m1*v1, shifts it and saturates it.
// Stages: operand select, multiply, add and shift, saturate into the output.
// ----------------------------------------------------------------------------
module vat_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  vat_pkg::coef_t coef,
    input  logic           vtx_valid,
    input  vat_pkg::vtx_t  vtx,
    output logic           vtx_stall,
    output logic           res_valid,
    input  logic           res_stall,
    output vat_pkg::res_t  res
);

    localparam int Lanes = 3;
    localparam int CW    = vat_pkg::CoordW;
    localparam int PW    = 2 * CW;
    localparam int SW    = PW + 1;

    localparam logic signed [CW-1:0] UnitCoef = CW'(1);

    typedef enum logic [1:0] {
        SH_0,
        SH_16,
        SH_30
    } shift_t;

    logic signed [CW-1:0] crd    [Lanes];
    logic signed [CW-1:0] op_m0  [Lanes];
    logic signed [CW-1:0] op_v0  [Lanes];
    logic signed [CW-1:0] op_m1  [Lanes];
    logic signed [CW-1:0] op_v1  [Lanes];
    shift_t               op_sh  [Lanes];
    logic signed [CW-1:0] neg_sin;

    logic                 s1_valid_reg;
    logic                 s1_last_reg;
    logic signed [CW-1:0] s1_m0_reg [Lanes];
    logic signed [CW-1:0] s1_v0_reg [Lanes];
    logic signed [CW-1:0] s1_m1_reg [Lanes];
    logic signed [CW-1:0] s1_v1_reg [Lanes];
    shift_t               s1_sh_reg [Lanes];

    logic                 s2_valid_reg;
    logic                 s2_last_reg;
    logic signed [PW-1:0] s2_p0_reg [Lanes];
    logic signed [PW-1:0] s2_p1_reg [Lanes];
    shift_t               s2_sh_reg [Lanes];

    logic                 s3_valid_reg;
    logic                 s3_last_reg;
    logic signed [SW-1:0] s3_val_reg [Lanes];

    logic                 res_valid_reg;
    vat_pkg::res_t        res_reg;

    logic signed [SW-1:0] sum      [Lanes];
    logic signed [SW-1:0] shifted  [Lanes];
    logic [SW-CW:0]       hi_bits  [Lanes];
    logic [Lanes-1:0]     sat;
    logic signed [CW-1:0] clip     [Lanes];
    vat_pkg::res_t        res_next;

    logic en1;
    logic en2;
    logic en3;
    logic en4;

    // A stage moves when it is empty or the stage after it moves.
    always_comb
    begin
        en4 = !res_valid_reg || !res_stall;
        en3 = !s3_valid_reg || en4;
        en2 = !s2_valid_reg || en3;
        en1 = !s1_valid_reg || en2;
    end

    // Operand select: lanes not touched by the mode pass through as 1 * v.
    always_comb
    begin
        crd[0]  = vtx.vertex_x;
        crd[1]  = vtx.vertex_y;
        crd[2]  = vtx.vertex_z;
        neg_sin = -coef.sin_q30;
        for (int l = 0; l < Lanes; l++)
        begin
            op_m0[l] = UnitCoef;
            op_v0[l] = crd[l];
            op_m1[l] = '0;
            op_v1[l] = '0;
            op_sh[l] = SH_0;
        end
        case (coef.mode)
            vat_pkg::MODE_MOVE_X:
            begin
                op_m1[0] = UnitCoef;
                op_v1[0] = coef.offset;
            end
            vat_pkg::MODE_MOVE_Y:
            begin
                op_m1[1] = UnitCoef;
                op_v1[1] = coef.offset;
            end
            vat_pkg::MODE_MOVE_Z:
            begin
                op_m1[2] = UnitCoef;
                op_v1[2] = coef.offset;
            end
            vat_pkg::MODE_ROT_X:
            begin
                op_m0[1] = coef.cos_q30;
                op_v0[1] = crd[1];
                op_m1[1] = coef.sin_q30;
                op_v1[1] = crd[2];
                op_sh[1] = SH_30;
                op_m0[2] = neg_sin;
                op_v0[2] = crd[1];
                op_m1[2] = coef.cos_q30;
                op_v1[2] = crd[2];
                op_sh[2] = SH_30;
            end
            vat_pkg::MODE_ROT_Y:
            begin
                op_m0[0] = coef.cos_q30;
                op_v0[0] = crd[0];
                op_m1[0] = coef.sin_q30;
                op_v1[0] = crd[2];
                op_sh[0] = SH_30;
                op_m0[2] = neg_sin;
                op_v0[2] = crd[0];
                op_m1[2] = coef.cos_q30;
                op_v1[2] = crd[2];
                op_sh[2] = SH_30;
            end
            vat_pkg::MODE_ROT_Z:
            begin
                op_m0[0] = coef.cos_q30;
                op_v0[0] = crd[0];
                op_m1[0] = neg_sin;
                op_v1[0] = crd[1];
                op_sh[0] = SH_30;
                op_m0[1] = coef.sin_q30;
                op_v0[1] = crd[0];
                op_m1[1] = coef.cos_q30;
                op_v1[1] = crd[1];
                op_sh[1] = SH_30;
            end
            vat_pkg::MODE_SCALE:
            begin
                for (int l = 0; l < Lanes; l++)
                begin
                    op_m0[l] = coef.scale;
                    op_sh[l] = SH_16;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Exact sum of the two products, then the floor shift of the mode.
    always_comb
    begin
        for (int l = 0; l < Lanes; l++)
        begin
            sum[l] = $signed({s2_p0_reg[l][PW-1], s2_p0_reg[l]})
                   + $signed({s2_p1_reg[l][PW-1], s2_p1_reg[l]});
            case (s2_sh_reg[l])
                SH_16:   shifted[l] = sum[l] >>> 16;
                SH_30:   shifted[l] = sum[l] >>> 30;
                default: shifted[l] = sum[l];
            endcase
        end
    end

    // Saturation to 32 bits: the bits above the sign must all match it.
    always_comb
    begin
        for (int l = 0; l < Lanes; l++)
        begin
            hi_bits[l] = s3_val_reg[l][SW-1:CW-1];
            sat[l]     = !((&hi_bits[l]) || !(|hi_bits[l]));
            if (sat[l])
            begin
                clip[l] = s3_val_reg[l][SW-1] ? vat_pkg::SAT_MIN : vat_pkg::SAT_MAX;
            end
            else
            begin
                clip[l] = $signed(s3_val_reg[l][CW-1:0]);
            end
        end
        res_next.out_x    = clip[0];
        res_next.out_y    = clip[1];
        res_next.out_z    = clip[2];
        res_next.overflow = |sat;
        res_next.last_out = s3_last_reg;
    end

    // Valid bits of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= vtx_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                res_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en1 && vtx_valid)
        begin
            s1_last_reg <= vtx.last_in;
            for (int l = 0; l < Lanes; l++)
            begin
                s1_m0_reg[l] <= op_m0[l];
                s1_v0_reg[l] <= op_v0[l];
                s1_m1_reg[l] <= op_m1[l];
                s1_v1_reg[l] <= op_v1[l];
                s1_sh_reg[l] <= op_sh[l];
            end
        end
        if (en2)
        begin
            s2_last_reg <= s1_last_reg;
            for (int l = 0; l < Lanes; l++)
            begin
                s2_p0_reg[l] <= s1_m0_reg[l] * s1_v0_reg[l];
                s2_p1_reg[l] <= s1_m1_reg[l] * s1_v1_reg[l];
                s2_sh_reg[l] <= s1_sh_reg[l];
            end
        end
        if (en3)
        begin
            s3_last_reg <= s2_last_reg;
            for (int l = 0; l < Lanes; l++)
            begin
                s3_val_reg[l] <= shifted[l];
            end
        end
        if (en4)
        begin
            res_reg <= res_next;
        end
    end

    assign vtx_stall = !en1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- design/vertex_affine_transform_top.sv -----
// ----------------------------------------------------------------------------
// vertex_affine_transform_top: streaming 3D affine vertex transform
// Translates, rotates or scales signed Q16.16 vertices, one per cycle when not stalled.
// ----------------------------------------------------------------------------
// The block takes one vertex request per cycle while it does not stall its
// input, and returns the transformed vertex through a four-stage pipeline
// whose stages each hold a valid bit, so bubbles are squeezed out while the
// result side stalls. The mode, offset and scale registers take effect on
// the next vertex. Writing the angle register starts the cosine/sine
// sequencer, and vertex requests are stalled until it finishes: the series
// runs on one iterative 64-bit multiplier and one radix-2 divider, with two
// products for setup and one product and one quotient per series term.
// Configuration writes are always taken.
module vertex_affine_transform_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vat_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [vat_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                          vtx_valid,
    output logic                          vtx_stall,
    input  vat_pkg::vtx_t                 vtx,
    output logic                          res_valid,
    input  logic                          res_stall,
    output vat_pkg::res_t                 res
);

    localparam int CW = vat_pkg::CoordW;
    localparam int AW = vat_pkg::AngleW;
    localparam int MW = vat_pkg::ModeW;

    logic [MW-1:0]        mode_reg;
    logic signed [CW-1:0] offset_reg;
    logic signed [CW-1:0] scale_reg;

    logic                 cfg_write;
    logic                 angle_write;
    logic                 trig_busy;
    logic                 hold;
    logic                 dp_stall;
    logic signed [CW-1:0] cos_q30;
    logic signed [CW-1:0] sin_q30;
    vat_pkg::coef_t       coef;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign angle_write = cfg_write && (cfg_index == vat_pkg::REG_ANGLE);

    // Configuration registers; the angle lives in the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= vat_pkg::MODE_MOVE_X;
            offset_reg <= '0;
            scale_reg  <= vat_pkg::SCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                vat_pkg::REG_MODE:   mode_reg   <= cfg_data[MW-1:0];
                vat_pkg::REG_OFFSET: offset_reg <= $signed(cfg_data[CW-1:0]);
                vat_pkg::REG_SCALE:  scale_reg  <= $signed(cfg_data[CW-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    vat_trig u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (angle_write),
        .angle   ($signed(cfg_data[AW-1:0])),
        .busy    (trig_busy),
        .cos_q30 (cos_q30),
        .sin_q30 (sin_q30)
    );

    // Vertices wait while the coefficients are being recomputed.
    assign hold = trig_busy || angle_write;

    always_comb
    begin
        coef.mode    = mode_reg;
        coef.offset  = offset_reg;
        coef.scale   = scale_reg;
        coef.cos_q30 = cos_q30;
        coef.sin_q30 = sin_q30;
    end

    vat_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .vtx_valid (vtx_valid && !hold),
        .vtx       (vtx),
        .vtx_stall (dp_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    assign vtx_stall = dp_stall || hold;

    // An angle write must hold off vertices on the following cycle.
    a_angle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        angle_write |=> vtx_stall)
        else $error("vertex not held after angle write");

    // Settled coefficients stay within plus and minus one in Q30.
    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        !trig_busy |-> (cos_q30 <= vat_pkg::Q30_ONE && cos_q30 >= -vat_pkg::Q30_ONE
                        && sin_q30 <= vat_pkg::Q30_ONE && sin_q30 >= -vat_pkg::Q30_ONE))
        else $error("cosine or sine out of range");

    // A raised overflow flag comes with at least one clipped coordinate.
    a_ovf_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.overflow) |->
            (res.out_x == vat_pkg::SAT_MAX || res.out_x == vat_pkg::SAT_MIN
             || res.out_y == vat_pkg::SAT_MAX || res.out_y == vat_pkg::SAT_MIN
             || res.out_z == vat_pkg::SAT_MAX || res.out_z == vat_pkg::SAT_MIN))
        else $error("overflow flag without a saturated coordinate");

endmodule

// ----- sim/tb_vertex_affine_transform_top.sv -----
// ----------------------------------------------------------------------------
// tb_vertex_affine_transform_top: self-checking bench of the vertex transform
// Drives vertex requests and register writes, predicts every transformed
// vertex from its own fixed-point cosine/sine and saturation logic, and
// compares each result request field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_vertex_affine_transform_top;

    timeunit 1ns;
    timeprecision 1ps;

    import vat_pkg::*;

    // Mode code that selects no operation.
    localparam logic [ModeW-1:0] MODE_UNUSED = 3'd7;

    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1770;
    // The pipeline is four deep; a few spare cycles catch late extras.
    localparam int SETTLE_CYCLES = 12;
    // The cosine/sine sequencer alone holds vertices off while it runs.
    localparam int QUIET_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 200;

    localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;
    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
    localparam int FULL_TURN    = 46080;
    localparam int QUARTER_TURN = 11520;
    localparam int EIGHTH_TURN  = 5760;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;
    logic                vtx_valid = 1'b0;
    logic                vtx_stall;
    vtx_t                vtx       = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    res_t                res;

    // Shadow copy of the registers and the coefficients they imply.
    logic [ModeW-1:0]         mode_reg   = MODE_MOVE_X;
    logic signed [CoordW-1:0] offset_reg = '0;
    logic signed [AngleW-1:0] angle_reg  = '0;
    logic signed [CoordW-1:0] scale_reg  = SCALE_RESET;
    longint                   cos_q30    = 64'sd1073741824;
    longint                   sin_q30    = 64'sd0;

    // Transformed vertices still due from the block, oldest first.
    res_t transformed_q[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int res_hold_left  = 0;
    bit send_idle_en   = 1'b1;
    bit recv_idle_en   = 1'b1;

    vertex_affine_transform_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vtx_valid (vtx_valid),
        .vtx_stall (vtx_stall),
        .vtx       (vtx),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Unsigned Q2.62 product, truncated.
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Taylor series of sine (odd) or cosine in Q2.62; stops at a zero term.
    function automatic logic [63:0] taylor_sum(input logic [63:0] t, input bit odd);
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] d;
        t2   = q62_mul(t, t);
        term = odd ? t : ONE_Q62;
        sum  = term;
        for (int k = 1; k <= 24; k++)
        begin
            d = odd ? 64'(2 * k * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
            term = q62_mul(term, t2) / d;
            if (term == 64'd0)
                break;
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    function automatic longint q30_round(input logic [63:0] v);
        return longint'((v + 64'h8000_0000) >> 32);
    endfunction

    // Cosine and sine in Q2.30 of an angle in 1/128 degree.
    function automatic void compute_cos_sin(input int a, output longint c, output longint s);
        int          m;
        int          q;
        int          r;
        logic [63:0] unit;
        logic [63:0] t;
        longint      c0;
        longint      s0;
        unit = PI_Q62 / 64'd23040;
        m = a % FULL_TURN;
        if (m < 0)
            m += FULL_TURN;
        q = m / QUARTER_TURN;
        r = m % QUARTER_TURN;
        // Past an eighth turn, work from the complement with sine and cosine swapped.
        if (r <= EIGHTH_TURN)
        begin
            t  = 64'(r) * unit;
            s0 = q30_round(taylor_sum(t, 1'b1));
            c0 = q30_round(taylor_sum(t, 1'b0));
        end
        else
        begin
            t  = 64'(QUARTER_TURN - r) * unit;
            c0 = q30_round(taylor_sum(t, 1'b1));
            s0 = q30_round(taylor_sum(t, 1'b0));
        end
        case (q)
            0:
            begin
                c = c0;
                s = s0;
            end
            1:
            begin
                c = -s0;
                s = c0;
            end
            2:
            begin
                c = -c0;
                s = -s0;
            end
            default:
            begin
                c = s0;
                s = -c0;
            end
        endcase
    endfunction

    // Expected result of one vertex under the current register settings.
    function automatic res_t transform_vertex(input vtx_t v);
        longint                   x;
        longint                   y;
        longint                   z;
        longint                   off;
        longint                   f;
        longint                   nv [3];
        logic signed [CoordW-1:0] o [3];
        bit                       ov;
        res_t                     r;
        x     = longint'(v.vertex_x);
        y     = longint'(v.vertex_y);
        z     = longint'(v.vertex_z);
        off   = longint'(offset_reg);
        f     = longint'(scale_reg);
        nv[0] = x;
        nv[1] = y;
        nv[2] = z;
        case (mode_reg)
            MODE_MOVE_X: nv[0] = x + off;
            MODE_MOVE_Y: nv[1] = y + off;
            MODE_MOVE_Z: nv[2] = z + off;
            MODE_ROT_X:
            begin
                nv[1] = (cos_q30 * y + sin_q30 * z) >>> 30;
                nv[2] = (-sin_q30 * y + cos_q30 * z) >>> 30;
            end
            MODE_ROT_Y:
            begin
                nv[0] = (cos_q30 * x + sin_q30 * z) >>> 30;
                nv[2] = (-sin_q30 * x + cos_q30 * z) >>> 30;
            end
            MODE_ROT_Z:
            begin
                nv[0] = (cos_q30 * x - sin_q30 * y) >>> 30;
                nv[1] = (sin_q30 * x + cos_q30 * y) >>> 30;
            end
            MODE_SCALE:
            begin
                nv[0] = (x * f) >>> 16;
                nv[1] = (y * f) >>> 16;
                nv[2] = (z * f) >>> 16;
            end
            default: ;
        endcase
        // Saturate each coordinate and note whether any was clipped.
        ov = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (nv[i] > longint'(SAT_MAX))
            begin
                o[i] = SAT_MAX;
                ov   = 1'b1;
            end
            else if (nv[i] < longint'(SAT_MIN))
            begin
                o[i] = SAT_MIN;
                ov   = 1'b1;
            end
            else
                o[i] = 32'(nv[i]);
        end
        r.out_x    = o[0];
        r.out_y    = o[1];
        r.out_z    = o[2];
        r.overflow = ov;
        r.last_out = v.last_in;
        return r;
    endfunction

    function automatic vtx_t mk_vertex(input logic signed [CoordW-1:0] x,
                                       input logic signed [CoordW-1:0] y,
                                       input logic signed [CoordW-1:0] z,
                                       input logic last);
        vtx_t v;
        v.vertex_x = x;
        v.vertex_y = y;
        v.vertex_z = z;
        v.last_in  = last;
        return v;
    endfunction

    // Q16.16 value: extremes, values near the origin, or any bit pattern.
    function automatic logic signed [CoordW-1:0] rand_q16();
        case ($urandom_range(0, 9))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2, 3, 4: return 32'($urandom_range(0, 2097152)) - 32'sd1048576;
            default: return $urandom();
        endcase
    endfunction

    function automatic int rand_angle();
        case ($urandom_range(0, 7))
            0: return FULL_TURN;
            1: return -FULL_TURN;
            2: return EIGHTH_TURN;
            3: return -QUARTER_TURN;
            default: return int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN;
        endcase
    endfunction

    function automatic vtx_t rand_vertex();
        return mk_vertex(rand_q16(), rand_q16(), rand_q16(), 1'($urandom_range(0, 1)));
    endfunction

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (res_hold_left > 0)
        begin
            res_stall <= 1'b1;
            res_hold_left--;
        end
        else
            res_stall <= recv_idle_en && ($urandom_range(0, 99) < 8);
    end

    // Predict on every accepted vertex request, check every result request,
    // and track register writes.
    always @(posedge clk)
    begin : monitor
        res_t due;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (transformed_q.size() == 0)
                begin
                    $error("result request with no vertex outstanding");
                    mismatch_count++;
                end
                else
                begin
                    due = transformed_q.pop_front();
                    if (res.out_x !== due.out_x)
                    begin
                        $error("out_x: expected %0d, actual %0d", due.out_x, res.out_x);
                        mismatch_count++;
                    end
                    if (res.out_y !== due.out_y)
                    begin
                        $error("out_y: expected %0d, actual %0d", due.out_y, res.out_y);
                        mismatch_count++;
                    end
                    if (res.out_z !== due.out_z)
                    begin
                        $error("out_z: expected %0d, actual %0d", due.out_z, res.out_z);
                        mismatch_count++;
                    end
                    if (res.overflow !== due.overflow)
                    begin
                        $error("overflow: expected %0b, actual %0b", due.overflow, res.overflow);
                        mismatch_count++;
                    end
                    if (res.last_out !== due.last_out)
                    begin
                        $error("last_out: expected %0b, actual %0b", due.last_out, res.last_out);
                        mismatch_count++;
                    end
                end
            end
            if (vtx_valid && !vtx_stall)
                transformed_q.push_back(transform_vertex(vtx));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODE:   mode_reg   = cfg_data[ModeW-1:0];
                    REG_OFFSET: offset_reg = cfg_data;
                    REG_ANGLE:
                    begin
                        angle_reg = cfg_data[AngleW-1:0];
                        compute_cos_sin(int'(angle_reg), cos_q30, sin_q30);
                    end
                    REG_SCALE:  scale_reg  = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: too long without any request moving ends the run.
    always @(posedge clk)
    begin
        if (rst_n && !((cfg_valid && cfg_ready) || (vtx_valid && !vtx_stall) ||
                       (res_valid && !res_stall)))
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_vertex_affine_transform_top: FAIL");
                $finish;
            end
        end
        else
            quiet_cycles = 0;
    end

    // Drop the vertex request and wait until every result has come back.
    task automatic wait_drained();
        @(negedge clk);
        vtx_valid <= 1'b0;
        while (transformed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers are only written with the pipeline empty.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one vertex request, with a random gap first, and hold it until taken.
    task automatic send_vertex(input vtx_t v);
        @(negedge clk);
        while (send_idle_en && ($urandom_range(0, 99) < 8))
        begin
            vtx_valid <= 1'b0;
            @(negedge clk);
        end
        vtx       <= v;
        vtx_valid <= 1'b1;
        do
            @(posedge clk);
        while (vtx_stall);
    endtask

    // Registers as they come out of reset: move x by zero, then scale by one.
    task automatic test_reset_values();
        send_vertex(mk_vertex(SAT_MAX, SAT_MIN, 32'sd0, 1'b1));
        send_vertex(mk_vertex(SAT_MIN, SAT_MAX, -32'sd1, 1'b0));
        write_reg(REG_MODE, 32'(MODE_SCALE));
        send_vertex(mk_vertex(SAT_MAX, SAT_MIN, 32'sd12345, 1'b1));
    endtask

    // Translation along each axis, clipping at both ends.
    task automatic test_translate();
        write_reg(REG_OFFSET, SAT_MAX);
        write_reg(REG_MODE, 32'(MODE_MOVE_X));
        send_vertex(mk_vertex(SAT_MAX, 32'sd1, 32'sd2, 1'b0));
        write_reg(REG_MODE, 32'(MODE_MOVE_Y));
        send_vertex(mk_vertex(32'sd5, SAT_MAX, 32'sd7, 1'b1));
        write_reg(REG_OFFSET, SAT_MIN);
        write_reg(REG_MODE, 32'(MODE_MOVE_Z));
        send_vertex(mk_vertex(32'sd0, 32'sd0, SAT_MIN, 1'b0));
        send_vertex(mk_vertex(-32'sd1, 32'sd1, SAT_MAX, 1'b1));
        write_reg(REG_OFFSET, -32'sd65536);
        write_reg(REG_MODE, 32'(MODE_MOVE_X));
        send_vertex(mk_vertex(-32'sd98304, SAT_MIN, SAT_MAX, 1'b0));
    endtask

    task automatic rotate_case(input logic [ModeW-1:0] m, input int a, input vtx_t v);
        write_reg(REG_MODE, 32'(m));
        write_reg(REG_ANGLE, 32'(a));
        send_vertex(v);
    endtask

    // Rotations about each axis: eighth-turn boundary, quadrants, wrap-around.
    task automatic test_rotate();
        vtx_t big;
        vtx_t plain;
        vtx_t low;
        big   = mk_vertex(SAT_MAX, SAT_MAX, SAT_MAX, 1'b1);
        plain = mk_vertex(32'sd65536, -32'sd131072, 32'sd196608, 1'b0);
        low   = mk_vertex(SAT_MIN, SAT_MIN, SAT_MAX, 1'b0);
        rotate_case(MODE_ROT_X, EIGHTH_TURN, big);
        rotate_case(MODE_ROT_Y, EIGHTH_TURN + 1, plain);
        rotate_case(MODE_ROT_Z, QUARTER_TURN, low);
        rotate_case(MODE_ROT_Z, -1, plain);
        rotate_case(MODE_ROT_X, FULL_TURN, plain);
        rotate_case(MODE_ROT_Y, -FULL_TURN, low);
        rotate_case(MODE_ROT_Z, 2 * QUARTER_TURN, big);
        // Angles past a full turn in either direction wrap around.
        rotate_case(MODE_ROT_X, 65535, plain);
        rotate_case(MODE_ROT_Y, -65536, big);
    endtask

    // Scale by the extreme factors and by a negative fraction (floor rounding).
    task automatic test_scale();
        write_reg(REG_MODE, 32'(MODE_SCALE));
        write_reg(REG_SCALE, SAT_MAX);
        send_vertex(mk_vertex(SAT_MAX, -32'sd2, 32'sd65536, 1'b1));
        write_reg(REG_SCALE, SAT_MIN);
        send_vertex(mk_vertex(SAT_MIN, SAT_MAX, 32'sd1, 1'b0));
        write_reg(REG_SCALE, -32'sd32768);
        send_vertex(mk_vertex(-32'sd3, 32'sd3, SAT_MIN, 1'b1));
    endtask

    // The spare mode code passes the vertex through untouched.
    task automatic test_unused_mode();
        write_reg(REG_OFFSET, 32'sd12345678);
        write_reg(REG_MODE, 32'(MODE_UNUSED));
        send_vertex(mk_vertex(SAT_MIN, SAT_MAX, 32'sd42, 1'b1));
    endtask

    // Random register settings, each followed by a burst of random vertices.
    task automatic test_random_stream();
        int               sent;
        int               phase;
        int               burst;
        int               pick;
        logic [ModeW-1:0] m;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // A stretch of phases runs with neither side idling.
            send_idle_en = !(phase >= 8 && phase < 13);
            recv_idle_en = send_idle_en;
            pick = $urandom_range(0, 14);
            m = (pick == 14) ? MODE_UNUSED : 3'(pick % 7);
            write_reg(REG_MODE, 32'(m));
            if (m <= MODE_MOVE_Z || $urandom_range(0, 3) == 0)
                write_reg(REG_OFFSET, rand_q16());
            if (m == MODE_SCALE || $urandom_range(0, 3) == 0)
                write_reg(REG_SCALE, rand_q16());
            // The angle goes last, as its write starts the sequencer.
            if (m >= MODE_ROT_X && m <= MODE_ROT_Z && $urandom_range(0, 2) != 0)
                write_reg(REG_ANGLE, 32'(rand_angle()));
            burst = $urandom_range(10, 80);
            repeat (burst) send_vertex(rand_vertex());
            sent += burst;
            phase++;
        end
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    // The receiver holds off while vertices keep coming, so the block fills
    // up and stalls its input; then the sender pauses for a full drain.
    task automatic test_backpressure();
        wait_drained();
        send_idle_en  = 1'b0;
        res_hold_left = HOLD_CYCLES;
        repeat (24) send_vertex(rand_vertex());
        wait_drained();
        send_idle_en = 1'b1;
        repeat (8) send_vertex(rand_vertex());
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_translate();
        test_rotate();
        test_scale();
        test_unused_mode();
        test_backpressure();
        test_random_stream();
        wait_drained();
        if (mismatch_count == 0)
            $display("tb_vertex_affine_transform_top: PASS");
        else
            $display("tb_vertex_affine_transform_top: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
design/vat_pkg.sv
design/vat_mul64.sv
design/vat_div64.sv
design/vat_trig.sv
design/vat_datapath.sv
design/vertex_affine_transform_top.sv
sim/tb_vertex_affine_transform_top.sv
